>>> design/handle_slot_allocator_defines.svh
// assertion macros for the handle slot allocator
// included by the top level, no other dependencies
`ifndef HANDLE_SLOT_ALLOCATOR_DEFINES_SVH
`define HANDLE_SLOT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define HSA_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("handle slot allocator check failed");
`define HSA_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("handle slot allocator check failed");
`else
`define HSA_ASSERT_SAME(label, clk, rst, a, b)
`define HSA_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> design/hsa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the handle slot allocator
// no dependencies
package hsa_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int KEY_W      = $clog2(SLOT_COUNT);
  localparam int DEPTH_W    = KEY_W + 1;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

>>> design/hsa_ctrl.sv
`timescale 1ns / 1ps
// controller for the handle slot allocator: request capture and execute sequencing
// depends on hsa_pkg
module hsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output hsa_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.execute;
    end
  end

endmodule

>>> design/hsa_datapath.sv
`timescale 1ns / 1ps
// datapath for the handle slot allocator: live bit memory, free stack and counters
// depends on hsa_pkg
module hsa_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  hsa_pkg::cmd_t                 cmd,
  input  logic [hsa_pkg::MODE_W-1:0]    mode,
  input  logic [hsa_pkg::KEY_W-1:0]     key,
  output logic [hsa_pkg::STATUS_W-1:0]  status,
  output logic [hsa_pkg::KEY_W-1:0]     result_key,
  output logic [hsa_pkg::KEY_W-1:0]     live_count
);

  logic                          live_mem [hsa_pkg::SLOT_COUNT];
  logic [hsa_pkg::KEY_W-1:0]     free_stack [hsa_pkg::SLOT_COUNT];

  logic [hsa_pkg::MODE_W-1:0]    mode_q;
  logic [hsa_pkg::KEY_W-1:0]     key_q;
  logic                          live_rd;
  logic [hsa_pkg::KEY_W-1:0]     stk_rd;

  logic [hsa_pkg::DEPTH_W-1:0]   free_depth;
  logic [hsa_pkg::DEPTH_W-1:0]   free_depth_next;
  logic [hsa_pkg::DEPTH_W-1:0]   next_fresh;
  logic [hsa_pkg::DEPTH_W-1:0]   next_fresh_next;
  logic [hsa_pkg::KEY_W-1:0]     live_total;
  logic [hsa_pkg::KEY_W-1:0]     live_total_next;

  logic [hsa_pkg::KEY_W-1:0]     stk_top;
  logic                          range_bad;
  logic [hsa_pkg::STATUS_W-1:0]  chk;
  logic [hsa_pkg::STATUS_W-1:0]  st;
  logic [hsa_pkg::KEY_W-1:0]     got;
  logic                          live_we;
  logic [hsa_pkg::KEY_W-1:0]     live_wa;
  logic                          live_wd;
  logic                          stk_we;

  assign stk_top = free_depth[hsa_pkg::KEY_W-1:0] - hsa_pkg::KEY_W'(1);

  // capture the request and read both memories at the accept edge
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q  <= mode;
      key_q   <= key;
      live_rd <= live_mem[key];
      stk_rd  <= free_stack[stk_top];
    end
  end

  always_comb begin
    range_bad = (key_q == '0) || ({1'b0, key_q} >= next_fresh);
    if (range_bad) begin
      chk = hsa_pkg::ST_RANGE;
    end else if (!live_rd) begin
      chk = hsa_pkg::ST_NOT_LIVE;
    end else begin
      chk = hsa_pkg::ST_OK;
    end

    st              = chk;
    got             = '0;
    live_we         = 1'b0;
    live_wa         = key_q;
    live_wd         = 1'b0;
    stk_we          = 1'b0;
    free_depth_next = free_depth;
    next_fresh_next = next_fresh;
    live_total_next = live_total;

    case (mode_q)
      hsa_pkg::MODE_ALLOC: begin
        if (free_depth != '0) begin
          st              = hsa_pkg::ST_OK;
          got             = stk_rd;
          live_we         = 1'b1;
          live_wa         = stk_rd;
          live_wd         = 1'b1;
          free_depth_next = free_depth - hsa_pkg::DEPTH_W'(1);
          live_total_next = live_total + hsa_pkg::KEY_W'(1);
        end else if (next_fresh < hsa_pkg::DEPTH_W'(hsa_pkg::SLOT_COUNT)) begin
          st              = hsa_pkg::ST_OK;
          got             = next_fresh[hsa_pkg::KEY_W-1:0];
          live_we         = 1'b1;
          live_wa         = next_fresh[hsa_pkg::KEY_W-1:0];
          live_wd         = 1'b1;
          next_fresh_next = next_fresh + hsa_pkg::DEPTH_W'(1);
          live_total_next = live_total + hsa_pkg::KEY_W'(1);
        end else begin
          st = hsa_pkg::ST_FULL;
        end
      end
      hsa_pkg::MODE_FREE: begin
        if (chk == hsa_pkg::ST_OK) begin
          live_we         = 1'b1;
          live_wa         = key_q;
          live_wd         = 1'b0;
          live_total_next = live_total - hsa_pkg::KEY_W'(1);
          if (free_depth < hsa_pkg::DEPTH_W'(hsa_pkg::SLOT_COUNT)) begin
            stk_we          = 1'b1;
            free_depth_next = free_depth + hsa_pkg::DEPTH_W'(1);
          end
        end
      end
      default: begin
        st = chk;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && live_we) begin
      live_mem[live_wa] <= live_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && stk_we) begin
      free_stack[free_depth[hsa_pkg::KEY_W-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth <= '0;
      next_fresh <= hsa_pkg::DEPTH_W'(1);
      live_total <= '0;
    end else if (cmd.execute) begin
      free_depth <= free_depth_next;
      next_fresh <= next_fresh_next;
      live_total <= live_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status     <= st;
      result_key <= got;
    end
  end

  assign live_count = live_total;

endmodule

>>> design/handle_slot_allocator.sv
`timescale 1ns / 1ps
// top level of the handle slot allocator
// depends on hsa_pkg, hsa_ctrl, hsa_datapath and handle_slot_allocator_defines.svh
//
// usage:
// a request (mode, key) is taken at a rising edge with start high and busy low.
// mode 0 looks a key up, 1 allocates a key, 2 frees a key; mode 3 acts as lookup.
// the live bit and free stack top are read at that edge, the next cycle (busy
// high) checks and writes back, and the cycle after that shows status,
// result_key and live_count with done high for exactly one cycle.
// a new request can be taken only once busy is low again, after the read then
// write-back of the single-port live bit and free stack memories.
// the receiver cannot stall: each result must be taken in its done cycle.
// reset clears the counters and control only; live bits above the bump head
// are never read, so no clearing pass is needed and start is taken at once.
// live_count holds the live total after the latest request between strobes.
`include "handle_slot_allocator_defines.svh"
module handle_slot_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [hsa_pkg::MODE_W-1:0]    mode,
  input  logic [hsa_pkg::KEY_W-1:0]     key,
  output logic                          done,
  output logic [hsa_pkg::STATUS_W-1:0]  status,
  output logic [hsa_pkg::KEY_W-1:0]     result_key,
  output logic [hsa_pkg::KEY_W-1:0]     live_count
);

  hsa_pkg::cmd_t cmd;

  hsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  hsa_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (mode),
    .key        (key),
    .status     (status),
    .result_key (result_key),
    .live_count (live_count)
  );

  `HSA_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `HSA_ASSERT_NEXT(a_busy_then_done, clk, rst, busy, done && !busy)
  `HSA_ASSERT_SAME(a_done_not_busy, clk, rst, done, !busy)
  `HSA_ASSERT_SAME(a_key_only_on_ok, clk, rst, done && (status != hsa_pkg::ST_OK), result_key == '0)

endmodule

>>> dv/handle_slot_allocator_checker.sv
`timescale 1ns / 1ps
// request and result checker for the handle slot allocator testbench
// tracks live slots, freed keys and the bump head itself; depends on hsa_pkg
module handle_slot_allocator_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [hsa_pkg::MODE_W-1:0]   mode,
  input  logic [hsa_pkg::KEY_W-1:0]    key,
  input  logic                         done,
  input  logic [hsa_pkg::STATUS_W-1:0] status,
  input  logic [hsa_pkg::KEY_W-1:0]    result_key,
  input  logic [hsa_pkg::KEY_W-1:0]    live_count,
  output int                           fail_count,
  output int                           pending
);
  import hsa_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    handle;
    logic [KEY_W-1:0]    live;
  } alloc_outcome_t;

  bit               slot_live [SLOT_COUNT];
  logic [KEY_W-1:0] freed_keys [$];
  int               bump_head;
  logic [KEY_W-1:0] live_total;
  alloc_outcome_t   outcome_q [$];

  function automatic logic [STATUS_W-1:0] key_status(logic [KEY_W-1:0] k);
    if (k == '0 || int'(k) >= bump_head) return ST_RANGE;
    if (!slot_live[k]) return ST_NOT_LIVE;
    return ST_OK;
  endfunction

  function automatic alloc_outcome_t serve_request(logic [MODE_W-1:0] m,
                                                   logic [KEY_W-1:0] k);
    alloc_outcome_t o;
    o = '0;
    case (m)
      MODE_ALLOC: begin
        if (freed_keys.size() > 0) begin
          o.handle = freed_keys.pop_back();
          slot_live[o.handle] = 1'b1;
          live_total++;
          o.status = ST_OK;
        end else if (bump_head < SLOT_COUNT) begin
          o.handle = KEY_W'(bump_head);
          slot_live[o.handle] = 1'b1;
          bump_head++;
          live_total++;
          o.status = ST_OK;
        end else begin
          o.status = ST_FULL;
        end
      end
      MODE_FREE: begin
        o.status = key_status(k);
        if (o.status == ST_OK) begin
          slot_live[k] = 1'b0;
          if (freed_keys.size() < SLOT_COUNT) freed_keys.push_back(k);
          live_total--;
        end
      end
      // spare mode acts as a lookup
      default: o.status = key_status(k);
    endcase
    o.live = live_total;
    return o;
  endfunction

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    alloc_outcome_t want;
    if (rst) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      freed_keys.delete();
      outcome_q.delete();
      bump_head  = 1;
      live_total = '0;
      fail_count = 0;
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          report($sformatf("result with no request outstanding, status %0d key %0d",
                           status, result_key));
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status)
            report($sformatf("status got %0d expected %0d", status, want.status));
          if (result_key !== want.handle)
            report($sformatf("result_key got %0d expected %0d", result_key, want.handle));
          if (live_count !== want.live)
            report($sformatf("live_count got %0d expected %0d", live_count, want.live));
        end
      end
      if (start && !busy) outcome_q.push_back(serve_request(mode, key));
    end
    pending = outcome_q.size();
  end

endmodule

>>> dv/handle_slot_allocator_tb.sv
`timescale 1ns / 1ps
// testbench top for the handle slot allocator: clock, reset, request stimulus, verdict
// depends on hsa_pkg, handle_slot_allocator and handle_slot_allocator_checker
module handle_slot_allocator_tb;
  import hsa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [KEY_W-1:0]  TOP_KEY    = KEY_W'(SLOT_COUNT - 1);
  localparam int                CYCLE_LIMIT = 200000;

  logic                clk;
  logic                rst   = 1'b1;
  logic                start = 1'b0;
  logic [MODE_W-1:0]   mode  = '0;
  logic [KEY_W-1:0]    key   = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    result_key;
  logic [KEY_W-1:0]    live_count;

  int fail_count;
  int pending;
  int idle_pct;
  int allocs_sent;
  int cycle_count;

  handle_slot_allocator u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .key        (key),
    .done       (done),
    .status     (status),
    .result_key (result_key),
    .live_count (live_count)
  );

  handle_slot_allocator_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .key        (key),
    .done       (done),
    .status     (status),
    .result_key (result_key),
    .live_count (live_count),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      mode  <= MODE_W'($urandom);
      key   <= KEY_W'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    if (m == MODE_ALLOC) allocs_sent++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // keys mostly near the handles issued so far, so frees and lookups hit live slots
  task automatic random_mix(int count);
    int pick;
    int hi;
    repeat (count) begin
      pick = $urandom_range(99);
      hi = (allocs_sent + 1 > SLOT_COUNT - 1) ? SLOT_COUNT - 1 : allocs_sent + 1;
      if (pick < 40) send_request(MODE_ALLOC, KEY_W'($urandom));
      else if (pick < 75) send_request(MODE_FREE, KEY_W'($urandom_range(hi, 1)));
      else if (pick < 90) send_request(MODE_LOOKUP, KEY_W'($urandom_range(hi, 1)));
      else send_request(MODE_W'($urandom_range(3)), KEY_W'($urandom));
    end
  endtask

  task automatic release_mix(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70) send_request(MODE_FREE, KEY_W'($urandom_range(SLOT_COUNT - 1, 1)));
      else if (pick < 85) send_request(MODE_ALLOC, KEY_W'($urandom));
      else send_request(MODE_LOOKUP, KEY_W'($urandom));
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table, null key, beyond head, lifo reuse, double free
    send_request(MODE_LOOKUP, '0);
    send_request(MODE_LOOKUP, KEY_W'(1));
    send_request(MODE_FREE, '0);
    send_request(MODE_FREE, TOP_KEY);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, TOP_KEY);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_LOOKUP, KEY_W'(2));
    send_request(MODE_SPARE, KEY_W'(2));
    send_request(MODE_FREE, KEY_W'(2));
    send_request(MODE_FREE, KEY_W'(2));
    send_request(MODE_LOOKUP, KEY_W'(2));
    send_request(MODE_FREE, KEY_W'(3));
    send_request(MODE_FREE, KEY_W'(1));
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_LOOKUP, KEY_W'(5));
    send_request(MODE_SPARE, '0);

    random_mix(150);
    idle_pct = 69;
    random_mix(150);
    idle_pct = 0;
    release_mix(140);
    idle_pct = 36;
    random_mix(140);

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
